>>> rtl/core/prime_sieve_engine_assert.svh
// Assertion macros used by the checker file of the prime sieve engine.
`ifndef PRIME_SIEVE_ENGINE_ASSERT_SVH
`define PRIME_SIEVE_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prime sieve engine assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prime sieve engine assertion failed");

`endif

>>> rtl/core/pse_pkg.sv
`timescale 1ns / 1ps

package pse_pkg;

   localparam int DEF_MAX_LIMIT  = 4096;
   localparam int DEF_LIST_DEPTH = 1024;

   localparam int LIMIT_W = 13;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam int PRIME_W = 12;
   localparam int STEP_W  = 4;

   typedef struct packed {
      logic               operation;
      logic [LIMIT_W-1:0] limit;
      logic [INDEX_W-1:0] list_index;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] prime_count;
      logic [PRIME_W-1:0] prime_value;
      logic               value_valid;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NOP        = 4'd0,
      OP_LOAD       = 4'd1,
      OP_CNT_CLR    = 4'd2,
      OP_CLR_WR     = 4'd3,
      OP_N_INIT     = 4'd4,
      OP_RD_N       = 4'd5,
      OP_M_INIT     = 4'd6,
      OP_STRIKE     = 4'd7,
      OP_N_INC      = 4'd8,
      OP_K_INIT     = 4'd9,
      OP_SCAN       = 4'd10,
      OP_RESP_SIEVE = 4'd11,
      OP_LIST_RD    = 4'd12,
      OP_RESP_FETCH = 4'd13
   } dp_op_type;

   typedef enum logic [3:0] {
      C_NEVER      = 4'd0,
      C_ALWAYS     = 4'd1,
      C_NO_START   = 4'd2,
      C_IS_FETCH   = 4'd3,
      C_LIM_LT2    = 4'd4,
      C_K_MORE     = 4'd5,
      C_SQ_GT_LIM  = 4'd6,
      C_FLAG_SET   = 4'd7,
      C_M_MORE     = 4'd8
   } cond_type;

   localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] ST_DISPATCH = 4'd1;
   localparam logic [STEP_W-1:0] ST_LIMCHK   = 4'd2;
   localparam logic [STEP_W-1:0] ST_CLEAR    = 4'd3;
   localparam logic [STEP_W-1:0] ST_NINIT    = 4'd4;
   localparam logic [STEP_W-1:0] ST_OTEST    = 4'd5;
   localparam logic [STEP_W-1:0] ST_RDN      = 4'd6;
   localparam logic [STEP_W-1:0] ST_CHKN     = 4'd7;
   localparam logic [STEP_W-1:0] ST_STRIKE   = 4'd8;
   localparam logic [STEP_W-1:0] ST_NEXTN    = 4'd9;
   localparam logic [STEP_W-1:0] ST_SCANI    = 4'd10;
   localparam logic [STEP_W-1:0] ST_SCAN     = 4'd11;
   localparam logic [STEP_W-1:0] ST_DRAIN    = 4'd12;
   localparam logic [STEP_W-1:0] ST_RESP     = 4'd13;
   localparam logic [STEP_W-1:0] ST_FRD      = 4'd14;
   localparam logic [STEP_W-1:0] ST_FRESP    = 4'd15;

   typedef struct packed {
      dp_op_type         op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ctl_type;

   typedef struct packed {
      logic is_fetch;
      logic lim_lt2;
      logic k_more;
      logic sq_gt_lim;
      logic flag_set;
      logic m_more;
   } dp_status_type;

   function automatic ctl_type microcode(input logic [STEP_W-1:0] step);
      ctl_type word;
      word = '{op: OP_NOP, cond: C_NEVER, target: ST_IDLE};
      unique case (step)
         ST_IDLE:     word = '{op: OP_LOAD,       cond: C_NO_START,  target: ST_IDLE};
         ST_DISPATCH: word = '{op: OP_NOP,        cond: C_IS_FETCH,  target: ST_FRD};
         ST_LIMCHK:   word = '{op: OP_CNT_CLR,    cond: C_LIM_LT2,   target: ST_RESP};
         ST_CLEAR:    word = '{op: OP_CLR_WR,     cond: C_K_MORE,    target: ST_CLEAR};
         ST_NINIT:    word = '{op: OP_N_INIT,     cond: C_NEVER,     target: ST_IDLE};
         ST_OTEST:    word = '{op: OP_NOP,        cond: C_SQ_GT_LIM, target: ST_SCANI};
         ST_RDN:      word = '{op: OP_RD_N,       cond: C_NEVER,     target: ST_IDLE};
         ST_CHKN:     word = '{op: OP_M_INIT,     cond: C_FLAG_SET,  target: ST_NEXTN};
         ST_STRIKE:   word = '{op: OP_STRIKE,     cond: C_M_MORE,    target: ST_STRIKE};
         ST_NEXTN:    word = '{op: OP_N_INC,      cond: C_ALWAYS,    target: ST_OTEST};
         ST_SCANI:    word = '{op: OP_K_INIT,     cond: C_NEVER,     target: ST_IDLE};
         ST_SCAN:     word = '{op: OP_SCAN,       cond: C_K_MORE,    target: ST_SCAN};
         ST_DRAIN:    word = '{op: OP_NOP,        cond: C_NEVER,     target: ST_IDLE};
         ST_RESP:     word = '{op: OP_RESP_SIEVE, cond: C_ALWAYS,    target: ST_IDLE};
         ST_FRD:      word = '{op: OP_LIST_RD,    cond: C_NEVER,     target: ST_IDLE};
         ST_FRESP:    word = '{op: OP_RESP_FETCH, cond: C_ALWAYS,    target: ST_IDLE};
         default:     word = '{op: OP_NOP,        cond: C_ALWAYS,    target: ST_IDLE};
      endcase
      return word;
   endfunction

endpackage

>>> rtl/core/pse_sequencer.sv
`timescale 1ns / 1ps

module pse_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  pse_pkg::dp_status_type status,
   output pse_pkg::ctl_type       ctl,
   output logic                  busy
);

   logic [pse_pkg::STEP_W-1:0] pc_ff;
   logic [pse_pkg::STEP_W-1:0] pc_in;
   logic                       take;

   assign ctl  = pse_pkg::microcode(pc_ff);
   assign busy = (pc_ff != pse_pkg::ST_IDLE);

   always_comb begin
      unique case (ctl.cond)
         pse_pkg::C_NEVER:     take = 1'b0;
         pse_pkg::C_ALWAYS:    take = 1'b1;
         pse_pkg::C_NO_START:  take = !start;
         pse_pkg::C_IS_FETCH:  take = status.is_fetch;
         pse_pkg::C_LIM_LT2:   take = status.lim_lt2;
         pse_pkg::C_K_MORE:    take = status.k_more;
         pse_pkg::C_SQ_GT_LIM: take = status.sq_gt_lim;
         pse_pkg::C_FLAG_SET:  take = status.flag_set;
         pse_pkg::C_M_MORE:    take = status.m_more;
         default:              take = 1'b1;
      endcase
      if (take) begin
         pc_in = ctl.target;
      end else begin
         pc_in = pc_ff + pse_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= pse_pkg::ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> rtl/core/pse_datapath.sv
`timescale 1ns / 1ps

module pse_datapath #(
   parameter int MAX_LIMIT  = pse_pkg::DEF_MAX_LIMIT,
   parameter int LIST_DEPTH = pse_pkg::DEF_LIST_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  pse_pkg::req_type       req_item,
   input  pse_pkg::ctl_type       ctl,
   output pse_pkg::dp_status_type status,
   output logic                   rsp_strobe,
   output pse_pkg::rsp_type       rsp_item
);

   localparam int NUM_W = $clog2(MAX_LIMIT + 1);
   localparam int FA_W  = $clog2(MAX_LIMIT);
   localparam int MW    = NUM_W + 2;
   localparam int LA_W  = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   logic                        flag_mem [MAX_LIMIT];
   logic [pse_pkg::PRIME_W-1:0] list_mem [LIST_DEPTH];

   logic                         op_ff;
   logic [NUM_W-1:0]             lim_ff;
   logic [pse_pkg::INDEX_W-1:0]  idx_ff;
   logic [NUM_W-1:0]             n_ff;
   logic [MW-1:0]                sq_ff;
   logic [MW-1:0]                m_ff;
   logic [FA_W-1:0]              k_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic                         pend_ff;
   logic [NUM_W-1:0]             pnum_ff;
   logic                         flag_rd_ff;
   logic [pse_pkg::PRIME_W-1:0]  list_rd_ff;
   logic                         fvalid_ff;
   logic                         strobe_ff;
   pse_pkg::rsp_type             rsp_ff;

   logic [NUM_W-1:0] lim_in;
   logic [MW-1:0]    m_next;
   logic [MW-1:0]    lim_ext;
   logic             k_last;
   logic             flag_we;
   logic [FA_W-1:0]  flag_wa;
   logic             flag_wd;
   logic [FA_W-1:0]  flag_ra;
   logic             list_we;
   logic             fvalid_in;

   assign lim_ext = MW'(lim_ff);
   assign m_next  = m_ff + MW'(n_ff);
   assign k_last  = (k_ff == FA_W'(lim_ff - NUM_W'(1)));

   assign status.is_fetch  = op_ff;
   assign status.lim_lt2   = (lim_ff < NUM_W'(2));
   assign status.k_more    = !k_last;
   assign status.sq_gt_lim = (sq_ff > lim_ext);
   assign status.flag_set  = flag_rd_ff;
   assign status.m_more    = (m_next <= lim_ext);

   always_comb begin
      if (32'(req_item.limit) > 32'(MAX_LIMIT)) begin
         lim_in = NUM_W'(MAX_LIMIT);
      end else begin
         lim_in = NUM_W'(req_item.limit);
      end
   end

   assign fvalid_in = (32'(idx_ff) < 32'(cnt_ff)) && (32'(idx_ff) < 32'(LIST_DEPTH));

   always_comb begin
      flag_we = 1'b0;
      flag_wa = k_ff;
      flag_wd = 1'b0;
      flag_ra = k_ff;
      case (ctl.op)
         pse_pkg::OP_CLR_WR: begin
            flag_we = 1'b1;
         end
         pse_pkg::OP_STRIKE: begin
            flag_we = 1'b1;
            flag_wa = FA_W'(m_ff - MW'(1));
            flag_wd = 1'b1;
         end
         pse_pkg::OP_RD_N: begin
            flag_ra = FA_W'(n_ff - NUM_W'(1));
         end
         default: begin
         end
      endcase
   end

   assign list_we = pend_ff && !flag_rd_ff && (cnt_ff != CNT_W'(LIST_DEPTH));

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_wa] <= flag_wd;
      end
      flag_rd_ff <= flag_mem[flag_ra];
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[LA_W'(cnt_ff)] <= pse_pkg::PRIME_W'(pnum_ff);
      end
      if (ctl.op == pse_pkg::OP_LIST_RD) begin
         list_rd_ff <= list_mem[LA_W'(idx_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == pse_pkg::OP_LOAD && accept) begin
         op_ff  <= req_item.operation;
         lim_ff <= lim_in;
         idx_ff <= req_item.list_index;
      end
      case (ctl.op)
         pse_pkg::OP_CNT_CLR: k_ff <= '0;
         pse_pkg::OP_CLR_WR:  k_ff <= k_ff + FA_W'(1);
         pse_pkg::OP_K_INIT:  k_ff <= FA_W'(1);
         pse_pkg::OP_SCAN:    k_ff <= k_ff + FA_W'(1);
         default: begin
         end
      endcase
      case (ctl.op)
         pse_pkg::OP_N_INIT: begin
            n_ff  <= NUM_W'(2);
            sq_ff <= MW'(4);
         end
         pse_pkg::OP_N_INC: begin
            n_ff  <= n_ff + NUM_W'(1);
            sq_ff <= sq_ff + MW'({n_ff, 1'b0}) + MW'(1);
         end
         default: begin
         end
      endcase
      case (ctl.op)
         pse_pkg::OP_M_INIT: m_ff <= sq_ff;
         pse_pkg::OP_STRIKE: m_ff <= m_next;
         default: begin
         end
      endcase
      if (ctl.op == pse_pkg::OP_SCAN) begin
         pnum_ff <= NUM_W'(k_ff) + NUM_W'(1);
      end
      if (ctl.op == pse_pkg::OP_LIST_RD) begin
         fvalid_ff <= fvalid_in;
      end
      if (ctl.op == pse_pkg::OP_RESP_SIEVE) begin
         rsp_ff.prime_count <= pse_pkg::COUNT_W'(cnt_ff);
         rsp_ff.prime_value <= '0;
         rsp_ff.value_valid <= 1'b0;
      end else if (ctl.op == pse_pkg::OP_RESP_FETCH) begin
         rsp_ff.prime_count <= pse_pkg::COUNT_W'(cnt_ff);
         rsp_ff.prime_value <= fvalid_ff ? list_rd_ff : '0;
         rsp_ff.value_valid <= fvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         pend_ff   <= (ctl.op == pse_pkg::OP_SCAN);
         strobe_ff <= (ctl.op == pse_pkg::OP_RESP_SIEVE) ||
                      (ctl.op == pse_pkg::OP_RESP_FETCH);
         if (ctl.op == pse_pkg::OP_CNT_CLR) begin
            cnt_ff <= '0;
         end else if (list_we) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

>>> rtl/core/prime_sieve_engine.sv
// After acceptance, a fetch transaction steps through dispatch, list read and fetch response.
// A sieve transaction with limit L (saturated to MAX_LIMIT) clears, strikes and scans flags;
// below 2, it goes from the limit check straight to the response. The response is registered.
// The receiver cannot stall, and a new transaction is accepted in the result cycle.
// Flags up to L are cleared in every sieve run with L of 2 or more, so reset needs no pass.
// Synchronous reset returns the sequencer to idle and clears the prime count.
`timescale 1ns / 1ps

module prime_sieve_engine #(
   parameter int MAX_LIMIT  = pse_pkg::DEF_MAX_LIMIT,
   parameter int LIST_DEPTH = pse_pkg::DEF_LIST_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pse_pkg::req_type req_item,
   output logic             rsp_strobe,
   output pse_pkg::rsp_type rsp_item
);

   pse_pkg::ctl_type       ctl;
   pse_pkg::dp_status_type status;
   logic                   accept;

   assign accept = start && !busy;

   pse_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctl    (ctl),
      .busy   (busy)
   );

   pse_datapath #(
      .MAX_LIMIT  (MAX_LIMIT),
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_item   (req_item),
      .ctl        (ctl),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

>>> rtl/core/pse_checker.sv
`timescale 1ns / 1ps
`include "prime_sieve_engine_assert.svh"

module pse_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input pse_pkg::req_type req_item,
   input logic             rsp_strobe,
   input pse_pkg::rsp_type rsp_item
);

   logic accepted;
   assign accepted = start && !busy && (req_item.operation || !req_item.operation);

   `PSE_ASSERT_NEXT(a_accept_busy, clock, reset, accepted, busy)
   `PSE_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `PSE_ASSERT_SAME(a_invalid_zero, clock, reset, rsp_strobe && !rsp_item.value_valid, rsp_item.prime_value == '0)
   `PSE_ASSERT_SAME(a_valid_count, clock, reset, rsp_strobe && rsp_item.value_valid, rsp_item.prime_count != '0)

endmodule

bind prime_sieve_engine pse_checker u_pse_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

>>> test/sieve_checker.sv
`timescale 1ns / 1ps

package sieve_tb_pkg;

   localparam logic REQ_SIEVE = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

endpackage

module sieve_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  pse_pkg::req_type req_item,
   input  logic             rsp_strobe,
   input  pse_pkg::rsp_type rsp_item,
   output int               error_count,
   output int               outstanding
);

   localparam int MAX_LIMIT  = pse_pkg::DEF_MAX_LIMIT;
   localparam int LIST_DEPTH = pse_pkg::DEF_LIST_DEPTH;

   bit                           struck [0:MAX_LIMIT];
   logic [pse_pkg::PRIME_W-1:0]  prime_store [LIST_DEPTH];
   logic [pse_pkg::COUNT_W-1:0]  found_count;
   pse_pkg::rsp_type             pending_responses [$];

   function automatic void run_sieve(input logic [pse_pkg::LIMIT_W-1:0] limit_in);
      int upper;
      int n;
      int m;
      int k;
      upper = (int'(limit_in) > MAX_LIMIT) ? MAX_LIMIT : int'(limit_in);
      for (k = 0; k <= MAX_LIMIT; k++) begin
         struck[k] = 1'b0;
      end
      found_count = '0;
      if (upper < 2) begin
         return;
      end
      for (n = 2; n * n <= upper; n++) begin
         if (!struck[n]) begin
            for (m = n * n; m <= upper; m += n) begin
               struck[m] = 1'b1;
            end
         end
      end
      for (k = 2; k <= upper; k++) begin
         if (!struck[k] && found_count < LIST_DEPTH) begin
            prime_store[found_count] = pse_pkg::PRIME_W'(k);
            found_count++;
         end
      end
   endfunction

   function automatic pse_pkg::rsp_type predict_response(input pse_pkg::req_type req);
      pse_pkg::rsp_type rsp;
      rsp = '0;
      if (req.operation == sieve_tb_pkg::REQ_SIEVE) begin
         run_sieve(req.limit);
      end else if (req.list_index < found_count) begin
         rsp.prime_value = prime_store[req.list_index];
         rsp.value_valid = 1'b1;
      end
      rsp.prime_count = found_count;
      return rsp;
   endfunction

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      pse_pkg::rsp_type want;
      if (reset) begin
         pending_responses.delete();
         found_count = '0;
      end else begin
         if (rsp_strobe) begin
            if (pending_responses.size() == 0) begin
               $error("Response transaction arrived with nothing outstanding.");
               error_count++;
            end else begin
               want = pending_responses.pop_front();
               check_field("prime_count", 16'(want.prime_count), 16'(rsp_item.prime_count));
               check_field("prime_value", 16'(want.prime_value), 16'(rsp_item.prime_value));
               check_field("value_valid", 16'(want.value_valid), 16'(rsp_item.value_valid));
            end
         end
         if (start && !busy) begin
            pending_responses.push_back(predict_response(req_item));
         end
      end
      outstanding <= pending_responses.size();
   end

endmodule

>>> test/tb_prime_sieve_engine.sv
`timescale 1ns / 1ps

module tb_prime_sieve_engine;

   localparam int IDLE_PCT     = 24;
   localparam int STALL_LIMIT  = 100000;
   localparam int RANDOM_ITEMS = 100;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   pse_pkg::req_type req_item;
   logic             rsp_strobe;
   pse_pkg::rsp_type rsp_item;
   int               error_count;
   int               outstanding;
   int               quiet_cycles = 0;
   int               sent = 0;
   bit               gaps_on = 1'b1;

   prime_sieve_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   sieve_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic issue_request(input logic op, input int limit, input int index);
      pse_pkg::req_type req;
      req.operation  = op;
      req.limit      = pse_pkg::LIMIT_W'(limit);
      req.list_index = pse_pkg::INDEX_W'(index);
      while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= req;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      sent++;
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic int pick_limit();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         return $urandom_range(0, 3);
      end else if (roll < 80) begin
         return $urandom_range(4, 300);
      end else if (roll < 92) begin
         return $urandom_range(301, 4095);
      end
      return $urandom_range(4096, 8191);
   endfunction

   // Most fetches aim below the likely prime count so that hits and misses both occur.
   function automatic int pick_index(input int limit);
      int upper;
      int bound;
      upper = (limit > pse_pkg::DEF_MAX_LIMIT) ? pse_pkg::DEF_MAX_LIMIT : limit;
      bound = (upper < 64) ? upper / 2 + 1 : upper / 5;
      if (bound > 1023) begin
         bound = 1023;
      end
      if ($urandom_range(0, 99) < 70) begin
         return $urandom_range(0, bound);
      end
      return $urandom_range(0, 1023);
   endfunction

   initial begin
      int roll;
      int limit;
      start    <= 1'b0;
      req_item <= '0;
      reset    <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      issue_request(sieve_tb_pkg::REQ_FETCH, 0, 0);
      issue_request(sieve_tb_pkg::REQ_SIEVE, 0, 0);
      issue_request(sieve_tb_pkg::REQ_FETCH, 0, 0);
      issue_request(sieve_tb_pkg::REQ_SIEVE, 1, 1023);
      issue_request(sieve_tb_pkg::REQ_SIEVE, 2, 0);
      issue_request(sieve_tb_pkg::REQ_FETCH, 8191, 0);
      issue_request(sieve_tb_pkg::REQ_FETCH, 0, 1);
      wait_for_results();
      issue_request(sieve_tb_pkg::REQ_SIEVE, 4096, 0);
      issue_request(sieve_tb_pkg::REQ_FETCH, 0, 0);
      issue_request(sieve_tb_pkg::REQ_FETCH, 0, 563);
      issue_request(sieve_tb_pkg::REQ_FETCH, 0, 564);
      issue_request(sieve_tb_pkg::REQ_FETCH, 0, 1023);
      issue_request(sieve_tb_pkg::REQ_SIEVE, 8191, 682);
      issue_request(sieve_tb_pkg::REQ_FETCH, 0, 563);
      issue_request(sieve_tb_pkg::REQ_SIEVE, 4097, 0);
      issue_request(sieve_tb_pkg::REQ_FETCH, 5461, 512);
      issue_request(sieve_tb_pkg::REQ_SIEVE, 9, 0);
      issue_request(sieve_tb_pkg::REQ_FETCH, 0, 3);
      issue_request(sieve_tb_pkg::REQ_FETCH, 0, 4);
      issue_request(sieve_tb_pkg::REQ_SIEVE, 25, 0);
      issue_request(sieve_tb_pkg::REQ_FETCH, 2730, 8);
      issue_request(sieve_tb_pkg::REQ_SIEVE, 3, 341);
      issue_request(sieve_tb_pkg::REQ_FETCH, 0, 1);
      wait_for_results();

      // Random phase: mostly a sieve followed by fetches, with stray requests mixed in.
      while (sent < RANDOM_ITEMS) begin
         gaps_on = !(sent >= 35 && sent < 65);
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            limit = pick_limit();
            issue_request(sieve_tb_pkg::REQ_SIEVE, limit, $urandom_range(0, 1023));
            repeat ($urandom_range(1, 6)) begin
               issue_request(sieve_tb_pkg::REQ_FETCH, $urandom_range(0, 8191),
                             pick_index(limit));
            end
         end else if (roll < 88) begin
            issue_request(sieve_tb_pkg::REQ_FETCH, $urandom_range(0, 8191),
                          $urandom_range(0, 1023));
         end else if (roll < 94) begin
            issue_request(sieve_tb_pkg::REQ_SIEVE, pick_limit(), $urandom_range(0, 1023));
         end else begin
            wait_for_results();
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
